@@ hdl/fenwick_prefix_sum_table_assert.svh @@
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table assertion macros
// Immediate-consequent and next-cycle checks, dropped when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH
`ifndef SYNTH
`define FPST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fenwick table check failed");
`define FPST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fenwick table check failed");
`else
`define FPST_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FPST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/fpst_pkg.sv @@
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table package
// Shared widths, opcodes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpst_pkg;

   localparam int SUM_W           = 32;
   localparam int POSITION_W      = 11;
   localparam int SIZE_W          = 11;
   localparam int MAX_ENTRIES_DEF = 1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic add_step;
      logic qry_step;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic pos_live;
      logic pos_nonzero;
      logic rsp_free;
   } status_type;

endpackage

@@ hdl/fpst_ram.sv @@
// ----------------------------------------------------------------------------
// Fenwick table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fpst_datapath.sv @@
// ----------------------------------------------------------------------------
// Fenwick table datapath
// Position walker, tree RAM, read-modify-write and sum accumulation, size
// register and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpst_datapath #(
   parameter int MAX_ENTRIES = fpst_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fpst_pkg::cmd_type                      cmd,
   output fpst_pkg::status_type                   status,
   input  logic                                   req_opcode,
   input  logic [fpst_pkg::POSITION_W-1:0]        req_position,
   input  logic signed [fpst_pkg::SUM_W-1:0]      req_delta,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fpst_pkg::SUM_W-1:0]      rsp_prefix_sum,
   input  logic                                   csr_wr_en,
   input  logic [fpst_pkg::SIZE_W-1:0]            csr_wr_data
);
   import fpst_pkg::*;

   localparam int AddrW = $clog2(MAX_ENTRIES);
   // wide enough for twice the store size and for any request position
   localparam int PosMin = $clog2(MAX_ENTRIES + 1) + 1;
   localparam int PosW   = (PosMin > POSITION_W + 1) ? PosMin : POSITION_W + 1;
   localparam logic [PosW-1:0]  MaxPos   = PosW'(MAX_ENTRIES);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_ENTRIES - 1);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [AddrW-1:0]  clear_ff, clear_in;
   logic              wb_pend_ff, wb_pend_in;
   logic              acc_pend_ff, acc_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [AddrW-1:0]  wb_addr_ff, wb_addr_in;
   logic [SUM_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [PosW-1:0]   size_ext, limit, req_pos_ext, pos_low;
   logic [AddrW-1:0]  node_addr;
   logic              ram_wr_en, ram_rd_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [SUM_W-1:0]  ram_wr_data, ram_rd_data;

   always_comb begin
      size_ext    = PosW'(size_ff);
      limit       = (size_ext > MaxPos) ? MaxPos : size_ext;
      req_pos_ext = PosW'(req_position);
      pos_low     = pos_ff & (~pos_ff + PosW'(1));
      node_addr   = AddrW'(pos_ff - PosW'(1));

      size_in      = csr_wr_en ? csr_wr_data : size_ff;
      clear_in     = cmd.clear_step ? clear_ff + AddrW'(1) : clear_ff;
      pos_in       = pos_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      wb_addr_in   = wb_addr_ff;
      wb_pend_in   = cmd.add_step;
      acc_pend_in  = cmd.qry_step;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         // clamp queries to the size in use; adds past it are simply not live
         pos_in   = (req_opcode == OP_QUERY && req_pos_ext > limit) ? limit : req_pos_ext;
         delta_in = req_delta;
         sum_in   = '0;
      end else if (cmd.add_step) begin
         pos_in     = pos_ff + pos_low;
         wb_addr_in = node_addr;
      end else if (cmd.qry_step) begin
         pos_in = pos_ff - pos_low;
      end

      if (acc_pend_ff) begin
         sum_in = sum_ff + ram_rd_data;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sum_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      ram_rd_en = cmd.add_step | cmd.qry_step;
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wb_pend_ff;
         ram_wr_addr = wb_addr_ff;
         ram_wr_data = ram_rd_data + delta_ff;
      end

      status.clear_last  = (clear_ff == LastAddr);
      status.pos_nonzero = (pos_ff != '0);
      status.pos_live    = (pos_ff != '0) && (pos_ff <= limit);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         clear_ff     <= '0;
         wb_pend_ff   <= 1'b0;
         acc_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         clear_ff     <= clear_in;
         wb_pend_ff   <= wb_pend_in;
         acc_pend_ff  <= acc_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      delta_ff    <= delta_in;
      sum_ff      <= sum_in;
      wb_addr_ff  <= wb_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   fpst_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (node_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prefix_sum = rsp_data_ff;

endmodule

@@ hdl/fpst_controller.sv @@
// ----------------------------------------------------------------------------
// Fenwick table controller
// Sequences the clear sweep, tree climbs for adds and descents for queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpst_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_ready,
   input  fpst_pkg::status_type status,
   output fpst_pkg::cmd_type    cmd
);
   import fpst_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_QRY   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_opcode == OP_QUERY) ? ST_QRY : ST_ADD;
            end
         end
         ST_ADD: begin
            // last write-back lands in the cycle that leaves this state
            if (status.pos_live) begin
               cmd.add_step = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            if (status.pos_nonzero) begin
               cmd.qry_step = 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the response register is free
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/fenwick_prefix_sum_table.sv @@
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: binary indexed tree over a single-port-pair RAM
// Add: one RAM read per node, write-back overlapped.
// Query: result held in a register until taken.
// Reset: synchronous; a sweep zeros every RAM entry before ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fenwick_prefix_sum_table_assert.svh"
module fenwick_prefix_sum_table #(
   parameter int MAX_ENTRIES = fpst_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [fpst_pkg::POSITION_W-1:0]   req_position,
   input  logic signed [fpst_pkg::SUM_W-1:0] req_delta,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fpst_pkg::SUM_W-1:0] rsp_prefix_sum,
   input  logic                              csr_wr_en,
   input  logic [fpst_pkg::SIZE_W-1:0]       csr_wr_data
);
   import fpst_pkg::*;

   cmd_type    cmd;
   status_type status;

   fpst_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   fpst_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_delta      (req_delta),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prefix_sum (rsp_prefix_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   `FPST_ASSERT_NOW(a_no_req_in_clear, clock, reset, cmd.clear_step, !req_ready)
   `FPST_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `FPST_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, status.rsp_free)
   `FPST_ASSERT_NOW(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(cmd))

endmodule
